### rtl/core/liquid_level_interlock_alarm_assert.svh
// ----------------------------------------------------------------------------
// Liquid level interlock alarm assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LIQUID_LEVEL_INTERLOCK_ALARM_ASSERT_SVH
`define LIQUID_LEVEL_INTERLOCK_ALARM_ASSERT_SVH
`ifndef ASSERT_OFF
`define LLIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LLIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LLIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LLIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/llia_pkg.sv
// ----------------------------------------------------------------------------
// Liquid level interlock alarm package
// Shared constants, register indexes, alarm mode codes and payload types.
// ----------------------------------------------------------------------------
package llia_pkg;

	localparam int LONG_COUNT_BITS_DEF  = 24;
	localparam int SHORT_COUNT_BITS_DEF = 16;
	localparam int PHASE_BITS           = 5;
	localparam int CFG_INDEX_BITS       = 3;
	localparam int CFG_DATA_BITS        = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_IVL    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LATER_IVL    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EARLY_PHASES = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DRY_ALARM    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_LENGTH = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEEP_HALF    = 3'd6;

	localparam logic [15:0] DEBOUNCE_RST     = 16'd1000;
	localparam logic [23:0] FIRST_IVL_RST    = 24'd30000;
	localparam logic [23:0] LATER_IVL_RST    = 24'd60000;
	localparam logic [3:0]  EARLY_PHASES_RST = 4'd5;
	localparam logic [23:0] DRY_ALARM_RST    = 24'd300000;
	localparam logic [23:0] ALARM_LENGTH_RST = 24'd180000;
	localparam logic [15:0] BEEP_HALF_RST    = 16'd1000;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_ACTIVE = 2'd1;
	localparam logic [1:0] MODE_SILENT = 2'd2;

	typedef struct packed {
		logic level_pin;
		logic flow_pin;
	} tick_t;

	typedef struct packed {
		logic liquid_ok;
		logic dry_fault;
		logic flow_ok;
		logic cooling_ok;
		logic alarm_on;
		logic buzzer;
	} result_t;

	typedef struct packed {
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  value;
	} cfg_req_t;

	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [23:0] first_interval_ticks;
		logic [23:0] later_interval_ticks;
		logic [3:0]  early_phase_count;
		logic [23:0] dry_alarm_ticks;
		logic [23:0] alarm_length_ticks;
		logic [15:0] beep_half_period_ticks;
	} cfg_regs_t;

endpackage

### rtl/core/llia_chan_if.sv
// ----------------------------------------------------------------------------
// Liquid level interlock alarm channel
// Valid/ready channel carrying one request payload of a chosen type.
// ----------------------------------------------------------------------------
interface llia_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/liquid_level_interlock_alarm.sv
// ----------------------------------------------------------------------------
// Liquid level interlock alarm
// Pipeline: an accepted tick is held in the input register, then its result in
// the result register, which offers it. Throughput: one tick per cycle while
// the sink takes results. While a finished result waits for the sink, the
// input register takes one more tick and then holds off further ticks.
// Reset: arst_n clears all counters and flags, opens a detect window and
// loads the register defaults; the block is ready right after reset.
// ----------------------------------------------------------------------------
`include "liquid_level_interlock_alarm_assert.svh"

module liquid_level_interlock_alarm #(
	parameter int LONG_COUNT_BITS  = llia_pkg::LONG_COUNT_BITS_DEF,
	parameter int SHORT_COUNT_BITS = llia_pkg::SHORT_COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	llia_chan_if.sink    cfg,
	llia_chan_if.sink    tick_in,
	llia_chan_if.source  result_out
);
	import llia_pkg::*;

	cfg_regs_t cfg_q;
	cfg_req_t  cfg_req;
	tick_t     tick_s1;
	logic      valid_s1;
	result_t   result_s2;
	logic      valid_s2;
	logic      advance;
	logic      liquid_ok_n;
	logic      dry_fault_n;
	logic      flow_ok_n;
	logic      alarm_on_n;
	logic      buzzer_n;

	assign cfg_req   = cfg.data;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks         <= DEBOUNCE_RST;
			cfg_q.first_interval_ticks   <= FIRST_IVL_RST;
			cfg_q.later_interval_ticks   <= LATER_IVL_RST;
			cfg_q.early_phase_count      <= EARLY_PHASES_RST;
			cfg_q.dry_alarm_ticks        <= DRY_ALARM_RST;
			cfg_q.alarm_length_ticks     <= ALARM_LENGTH_RST;
			cfg_q.beep_half_period_ticks <= BEEP_HALF_RST;
		end else if (cfg.valid) begin
			case (cfg_req.index)
				REG_DEBOUNCE:     cfg_q.debounce_ticks         <= cfg_req.value[15:0];
				REG_FIRST_IVL:    cfg_q.first_interval_ticks   <= cfg_req.value;
				REG_LATER_IVL:    cfg_q.later_interval_ticks   <= cfg_req.value;
				REG_EARLY_PHASES: cfg_q.early_phase_count      <= cfg_req.value[3:0];
				REG_DRY_ALARM:    cfg_q.dry_alarm_ticks        <= cfg_req.value;
				REG_ALARM_LENGTH: cfg_q.alarm_length_ticks     <= cfg_req.value;
				REG_BEEP_HALF:    cfg_q.beep_half_period_ticks <= cfg_req.value[15:0];
				default: begin
				end
			endcase
		end
	end

	assign advance       = valid_s1 && (!valid_s2 || result_out.ready);
	assign tick_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick_in.valid && tick_in.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) begin
			tick_s1 <= tick_in.data;
		end
		if (advance) begin
			result_s2.liquid_ok  <= liquid_ok_n;
			result_s2.dry_fault  <= dry_fault_n;
			result_s2.flow_ok    <= flow_ok_n;
			result_s2.cooling_ok <= liquid_ok_n && !dry_fault_n && flow_ok_n;
			result_s2.alarm_on   <= alarm_on_n;
			result_s2.buzzer     <= buzzer_n;
		end
	end

	llia_level #(
		.LONG_COUNT_BITS  (LONG_COUNT_BITS),
		.SHORT_COUNT_BITS (SHORT_COUNT_BITS)
	) u_level (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.wet         (!tick_s1.level_pin),
		.cfg         (cfg_q),
		.liquid_ok_n (liquid_ok_n),
		.dry_fault_n (dry_fault_n)
	);

	llia_flow #(
		.SHORT_COUNT_BITS (SHORT_COUNT_BITS)
	) u_flow (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.flow_valid (!tick_s1.flow_pin),
		.cfg        (cfg_q),
		.flow_ok_n  (flow_ok_n)
	);

	llia_alarm #(
		.LONG_COUNT_BITS  (LONG_COUNT_BITS),
		.SHORT_COUNT_BITS (SHORT_COUNT_BITS)
	) u_alarm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.liquid_ok  (liquid_ok_n),
		.cfg        (cfg_q),
		.alarm_on_n (alarm_on_n),
		.buzzer_n   (buzzer_n)
	);

	assign result_out.valid = valid_s2;
	assign result_out.data  = result_s2;

	`LLIA_ASSERT_IMP(a_buzzer_needs_alarm, clk, arst_n, valid_s2 && result_s2.buzzer, result_s2.alarm_on, "Buzzer sounds without an active alarm.")
	`LLIA_ASSERT_IMP(a_ok_fault_exclusive, clk, arst_n, valid_s2, !(result_s2.liquid_ok && result_s2.dry_fault), "Liquid OK and dry fault are both set.")
	`LLIA_ASSERT_NXT(a_s1_holds_on_stall, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(tick_s1), "Input stage lost a stalled tick.")
endmodule

### rtl/core/llia_level.sv
// ----------------------------------------------------------------------------
// Liquid level interlock level qualifier
// Debounces the level pin inside detect windows, counts phases and times the
// wait between windows.
// ----------------------------------------------------------------------------
module llia_level #(
	parameter int LONG_COUNT_BITS  = 24,
	parameter int SHORT_COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                wet,
	input  llia_pkg::cfg_regs_t cfg,
	output logic                liquid_ok_n,
	output logic                dry_fault_n
);
	import llia_pkg::*;

	localparam logic [31:0] LONG_MAX = 32'((64'd1 << LONG_COUNT_BITS) - 64'd1);
	localparam logic [SHORT_COUNT_BITS-1:0] S_ONE = 1;
	localparam logic [LONG_COUNT_BITS-1:0]  L_ONE = 1;
	localparam logic [PHASE_BITS-1:0]       P_ONE = 1;

	logic [SHORT_COUNT_BITS-1:0] wet_run_q, wet_run_n;
	logic [SHORT_COUNT_BITS-1:0] dry_run_q, dry_run_n;
	logic                        ok_q, ok_n;
	logic                        fault_q, fault_n;
	logic                        window_q, window_n;
	logic [LONG_COUNT_BITS-1:0]  wait_q, wait_n;
	logic [PHASE_BITS-1:0]       phase_q, phase_n;
	logic                        close;
	logic [23:0]                 ivl;
	logic [31:0]                 ivl32;

	always_comb begin
		wet_run_n = wet_run_q;
		dry_run_n = dry_run_q;
		ok_n      = ok_q;
		fault_n   = fault_q;
		window_n  = window_q;
		wait_n    = wait_q;
		phase_n   = phase_q;
		close     = 1'b0;
		ivl       = cfg.first_interval_ticks;
		ivl32     = 32'(ivl);
		if (window_q) begin
			if (wet) begin
				wet_run_n = (wet_run_q == '1) ? wet_run_q : wet_run_q + S_ONE;
				dry_run_n = '0;
				close     = 32'(wet_run_n) >= 32'(cfg.debounce_ticks);
			end else begin
				dry_run_n = (dry_run_q == '1) ? dry_run_q : dry_run_q + S_ONE;
				wet_run_n = '0;
				close     = 32'(dry_run_n) >= 32'(cfg.debounce_ticks);
			end
			if (close) begin
				ok_n     = wet;
				fault_n  = !wet;
				window_n = 1'b0;
				phase_n  = (phase_q == '1) ? phase_q : phase_q + P_ONE;
				ivl      = (phase_n <= {1'b0, cfg.early_phase_count}) ?
					cfg.first_interval_ticks : cfg.later_interval_ticks;
				ivl32    = 32'(ivl);
				wait_n   = (ivl32 > LONG_MAX) ? LONG_MAX[LONG_COUNT_BITS-1:0] :
					ivl32[LONG_COUNT_BITS-1:0];
			end
		end else if (wait_q <= L_ONE) begin
			wait_n    = '0;
			window_n  = 1'b1;
			wet_run_n = '0;
			dry_run_n = '0;
		end else begin
			wait_n = wait_q - L_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_run_q <= '0;
			dry_run_q <= '0;
			ok_q      <= 1'b0;
			fault_q   <= 1'b0;
			window_q  <= 1'b1;
			wait_q    <= '0;
			phase_q   <= '0;
		end else if (step) begin
			wet_run_q <= wet_run_n;
			dry_run_q <= dry_run_n;
			ok_q      <= ok_n;
			fault_q   <= fault_n;
			window_q  <= window_n;
			wait_q    <= wait_n;
			phase_q   <= phase_n;
		end
	end

	assign liquid_ok_n = ok_n;
	assign dry_fault_n = fault_n;
endmodule

### rtl/core/llia_flow.sv
// ----------------------------------------------------------------------------
// Liquid level interlock flow debouncer
// Debounces the flow pin on every tick with saturating run counters.
// ----------------------------------------------------------------------------
module llia_flow #(
	parameter int SHORT_COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                flow_valid,
	input  llia_pkg::cfg_regs_t cfg,
	output logic                flow_ok_n
);
	import llia_pkg::*;

	localparam logic [SHORT_COUNT_BITS-1:0] S_ONE = 1;

	logic [SHORT_COUNT_BITS-1:0] on_run_q, on_run_n;
	logic [SHORT_COUNT_BITS-1:0] off_run_q, off_run_n;
	logic                        flag_q, flag_n;

	always_comb begin
		on_run_n  = on_run_q;
		off_run_n = off_run_q;
		flag_n    = flag_q;
		if (flow_valid) begin
			on_run_n  = (on_run_q == '1) ? on_run_q : on_run_q + S_ONE;
			off_run_n = '0;
			if (32'(on_run_n) >= 32'(cfg.debounce_ticks)) begin
				flag_n = 1'b1;
			end
		end else begin
			off_run_n = (off_run_q == '1) ? off_run_q : off_run_q + S_ONE;
			on_run_n  = '0;
			if (32'(off_run_n) >= 32'(cfg.debounce_ticks)) begin
				flag_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_run_q  <= '0;
			off_run_q <= '0;
			flag_q    <= 1'b0;
		end else if (step) begin
			on_run_q  <= on_run_n;
			off_run_q <= off_run_n;
			flag_q    <= flag_n;
		end
	end

	assign flow_ok_n = flag_n;
endmodule

### rtl/core/llia_alarm.sv
// ----------------------------------------------------------------------------
// Liquid level interlock dry-running alarm
// Times the absence of liquid, then sounds a toggling buzzer for a set length
// and holds a silent alarm until liquid returns.
// ----------------------------------------------------------------------------
module llia_alarm #(
	parameter int LONG_COUNT_BITS  = 24,
	parameter int SHORT_COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                liquid_ok,
	input  llia_pkg::cfg_regs_t cfg,
	output logic                alarm_on_n,
	output logic                buzzer_n
);
	import llia_pkg::*;

	localparam logic [SHORT_COUNT_BITS-1:0] S_ONE = 1;
	localparam logic [LONG_COUNT_BITS-1:0]  L_ONE = 1;

	logic [LONG_COUNT_BITS-1:0]  dry_time_q, dry_time_n;
	logic [LONG_COUNT_BITS-1:0]  alarm_time_q, alarm_time_n;
	logic [SHORT_COUNT_BITS-1:0] beep_time_q, beep_time_n;
	logic                        beep_level_q, beep_level_n;
	logic [1:0]                  mode_q, mode_n;

	always_comb begin
		dry_time_n   = dry_time_q;
		alarm_time_n = alarm_time_q;
		beep_time_n  = beep_time_q;
		beep_level_n = beep_level_q;
		mode_n       = mode_q;
		if (liquid_ok) begin
			dry_time_n = '0;
			if (mode_q != MODE_IDLE) begin
				mode_n       = MODE_IDLE;
				alarm_time_n = '0;
				beep_time_n  = '0;
				beep_level_n = 1'b0;
			end
		end else begin
			dry_time_n = (dry_time_q == '1) ? dry_time_q : dry_time_q + L_ONE;
			if (mode_q == MODE_IDLE && 32'(dry_time_n) >= 32'(cfg.dry_alarm_ticks)) begin
				mode_n       = MODE_ACTIVE;
				alarm_time_n = '0;
				beep_time_n  = '0;
				beep_level_n = 1'b1;
			end
		end
		if (mode_n == MODE_ACTIVE) begin
			beep_time_n = (beep_time_n == '1) ? beep_time_n : beep_time_n + S_ONE;
			if (32'(beep_time_n) >= 32'(cfg.beep_half_period_ticks)) begin
				beep_time_n  = '0;
				beep_level_n = !beep_level_n;
			end
			alarm_time_n = (alarm_time_n == '1) ? alarm_time_n : alarm_time_n + L_ONE;
			if (32'(alarm_time_n) >= 32'(cfg.alarm_length_ticks)) begin
				mode_n       = MODE_SILENT;
				beep_level_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_time_q   <= '0;
			alarm_time_q <= '0;
			beep_time_q  <= '0;
			beep_level_q <= 1'b0;
			mode_q       <= MODE_IDLE;
		end else if (step) begin
			dry_time_q   <= dry_time_n;
			alarm_time_q <= alarm_time_n;
			beep_time_q  <= beep_time_n;
			beep_level_q <= beep_level_n;
			mode_q       <= mode_n;
		end
	end

	assign alarm_on_n = (mode_n != MODE_IDLE);
	assign buzzer_n   = beep_level_n;
endmodule

### bench/interlock_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interlock status checker
// Watches the register, tick and status channels of the liquid level
// interlock. A model of the interlock runs on every accepted
// tick and queues the status it should produce. Each accepted status is then
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module interlock_status_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  llia_pkg::cfg_req_t cfg_data,
	input  logic               tick_valid,
	input  logic               tick_ready,
	input  llia_pkg::tick_t    tick_data,
	input  logic               status_valid,
	input  logic               status_ready,
	input  llia_pkg::result_t  status_data,
	output int                 mismatch_count,
	output int                 pending
);
	import llia_pkg::*;

	cfg_regs_t   regs;
	logic [15:0] wet_run;
	logic [15:0] dry_run;
	logic [15:0] flow_on_run;
	logic [15:0] flow_off_run;
	logic        level_ok;
	logic        level_fault;
	logic        flow_flag;
	logic        window_open;
	logic [23:0] wait_count;
	logic [4:0]  phase_count;
	logic [23:0] dry_time;
	logic [23:0] alarm_time;
	logic [15:0] beep_time;
	logic        beep_level;
	logic [1:0]  alarm_mode;

	result_t     expected_status_q[$];
	result_t     predicted;
	result_t     oldest;
	int          status_count;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [23:0] sat_inc24(input logic [23:0] v);
		return (v == 24'hFFFFFF) ? v : v + 24'd1;
	endfunction

	task automatic clear_interlock();
		regs.debounce_ticks         = DEBOUNCE_RST;
		regs.first_interval_ticks   = FIRST_IVL_RST;
		regs.later_interval_ticks   = LATER_IVL_RST;
		regs.early_phase_count      = EARLY_PHASES_RST;
		regs.dry_alarm_ticks        = DRY_ALARM_RST;
		regs.alarm_length_ticks     = ALARM_LENGTH_RST;
		regs.beep_half_period_ticks = BEEP_HALF_RST;
		wet_run      = '0;
		dry_run      = '0;
		flow_on_run  = '0;
		flow_off_run = '0;
		level_ok     = 1'b0;
		level_fault  = 1'b0;
		flow_flag    = 1'b0;
		window_open  = 1'b1;
		wait_count   = '0;
		phase_count  = '0;
		dry_time     = '0;
		alarm_time   = '0;
		beep_time    = '0;
		beep_level   = 1'b0;
		alarm_mode   = MODE_IDLE;
	endtask

	task automatic write_register(input cfg_req_t req);
		case (req.index)
			REG_DEBOUNCE: begin
				regs.debounce_ticks = req.value[15:0];
			end
			REG_FIRST_IVL: begin
				regs.first_interval_ticks = req.value;
			end
			REG_LATER_IVL: begin
				regs.later_interval_ticks = req.value;
			end
			REG_EARLY_PHASES: begin
				regs.early_phase_count = req.value[3:0];
			end
			REG_DRY_ALARM: begin
				regs.dry_alarm_ticks = req.value;
			end
			REG_ALARM_LENGTH: begin
				regs.alarm_length_ticks = req.value;
			end
			REG_BEEP_HALF: begin
				regs.beep_half_period_ticks = req.value[15:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic close_window(input logic wet);
		level_ok    = wet;
		level_fault = ~wet;
		window_open = 1'b0;
		if (phase_count != 5'd31) begin
			phase_count = phase_count + 5'd1;
		end
		wait_count = (phase_count <= regs.early_phase_count) ? regs.first_interval_ticks
			: regs.later_interval_ticks;
	endtask

	task automatic advance_interlock(input tick_t t, output result_t r);
		logic wet;
		logic flow_valid;
		wet        = ~t.level_pin;
		flow_valid = ~t.flow_pin;

		if (window_open) begin
			if (wet) begin
				wet_run = sat_inc16(wet_run);
				dry_run = '0;
				if (wet_run >= regs.debounce_ticks) begin
					close_window(1'b1);
				end
			end else begin
				dry_run = sat_inc16(dry_run);
				wet_run = '0;
				if (dry_run >= regs.debounce_ticks) begin
					close_window(1'b0);
				end
			end
		end else if (wait_count <= 24'd1) begin
			wait_count  = '0;
			window_open = 1'b1;
			wet_run     = '0;
			dry_run     = '0;
		end else begin
			wait_count = wait_count - 24'd1;
		end

		if (flow_valid) begin
			flow_on_run  = sat_inc16(flow_on_run);
			flow_off_run = '0;
			if (flow_on_run >= regs.debounce_ticks) begin
				flow_flag = 1'b1;
			end
		end else begin
			flow_off_run = sat_inc16(flow_off_run);
			flow_on_run  = '0;
			if (flow_off_run >= regs.debounce_ticks) begin
				flow_flag = 1'b0;
			end
		end

		if (level_ok) begin
			dry_time = '0;
			if (alarm_mode != MODE_IDLE) begin
				alarm_mode = MODE_IDLE;
				alarm_time = '0;
				beep_time  = '0;
				beep_level = 1'b0;
			end
		end else begin
			dry_time = sat_inc24(dry_time);
			if (alarm_mode == MODE_IDLE && dry_time >= regs.dry_alarm_ticks) begin
				alarm_mode = MODE_ACTIVE;
				alarm_time = '0;
				beep_time  = '0;
				beep_level = 1'b1;
			end
		end

		if (alarm_mode == MODE_ACTIVE) begin
			beep_time = sat_inc16(beep_time);
			if (beep_time >= regs.beep_half_period_ticks) begin
				beep_time  = '0;
				beep_level = ~beep_level;
			end
			alarm_time = sat_inc24(alarm_time);
			if (alarm_time >= regs.alarm_length_ticks) begin
				alarm_mode = MODE_SILENT;
				beep_level = 1'b0;
			end
		end

		r.liquid_ok  = level_ok;
		r.dry_fault  = level_fault;
		r.flow_ok    = flow_flag;
		r.cooling_ok = level_ok & ~level_fault & flow_flag;
		r.alarm_on   = (alarm_mode != MODE_IDLE);
		r.buzzer     = beep_level;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic got, input logic want);
		if (got !== want) begin
			report_mismatch($sformatf("status %0d %s got %b want %b", status_count, name,
				got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_interlock();
			expected_status_q.delete();
			mismatch_count = 0;
			status_count   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				write_register(cfg_data);
			end
			if (tick_valid && tick_ready) begin
				advance_interlock(tick_data, predicted);
				expected_status_q.push_back(predicted);
			end
			if (status_valid && status_ready) begin
				if (expected_status_q.size() == 0) begin
					report_mismatch($sformatf("status %0d arrived with no tick pending",
						status_count));
				end else begin
					oldest = expected_status_q.pop_front();
					check_field("liquid_ok", status_data.liquid_ok, oldest.liquid_ok);
					check_field("dry_fault", status_data.dry_fault, oldest.dry_fault);
					check_field("flow_ok", status_data.flow_ok, oldest.flow_ok);
					check_field("cooling_ok", status_data.cooling_ok, oldest.cooling_ok);
					check_field("alarm_on", status_data.alarm_on, oldest.alarm_on);
					check_field("buzzer", status_data.buzzer, oldest.buzzer);
				end
				status_count++;
			end
		end
		pending = expected_status_q.size();
	end

endmodule

### bench/liquid_level_interlock_alarm_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Liquid level interlock alarm testbench
// Drives pin ticks and register writes into the interlock with random gaps
// and status stalls. A short directed pass covers every pin combination and
// all-zero limits; random phases follow with small timings so that windows,
// waits, alarms and saturation of the phase count all come into play, then a
// phase at the largest register values. The checker judges every status.
// ----------------------------------------------------------------------------
module liquid_level_interlock_alarm_test;
	import llia_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
	// Each pair is {level_pin, flow_pin}, first tick in the top bits.
	localparam logic [39:0] DIRECTED_TICKS =
		40'b00_01_10_11_00_00_10_10_11_01_00_10_01_11_00_00_10_00_01_10;

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   mismatch_count;
	int   pending;
	int   src_idle;
	int   sink_stall;
	int   run_cap;
	int   dry_bias;
	int   level_left;
	int   flow_left;
	logic level_dry;
	logic flow_off;

	llia_chan_if #(.payload_t(cfg_req_t)) cfg_ch ();
	llia_chan_if #(.payload_t(tick_t))    tick_ch ();
	llia_chan_if #(.payload_t(result_t))  status_ch ();

	liquid_level_interlock_alarm dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.tick_in    (tick_ch),
		.result_out (status_ch)
	);

	interlock_status_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_ch.valid),
		.cfg_ready      (cfg_ch.ready),
		.cfg_data       (cfg_ch.data),
		.tick_valid     (tick_ch.valid),
		.tick_ready     (tick_ch.ready),
		.tick_data      (tick_ch.data),
		.status_valid   (status_ch.valid),
		.status_ready   (status_ch.ready),
		.status_data    (status_ch.data),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		status_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_stall != 0 && $urandom_range(0, 15) < sink_stall * 2) begin
				status_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				status_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		cfg_req_t req;
		req.index = idx;
		req.value = val;
		if (src_idle != 0 && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= req;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_profile(input logic [15:0] debounce, input logic [23:0] first_ivl,
		input logic [23:0] later_ivl, input logic [3:0] early, input logic [23:0] dry_limit,
		input logic [23:0] alarm_len, input logic [15:0] beep_half);
		logic [23:0] junk;
		junk = 24'($urandom);
		write_reg(REG_DEBOUNCE, {junk[23:16], debounce});
		write_reg(REG_FIRST_IVL, first_ivl);
		write_reg(REG_LATER_IVL, later_ivl);
		write_reg(REG_EARLY_PHASES, {junk[19:0], early});
		write_reg(REG_DRY_ALARM, dry_limit);
		write_reg(REG_ALARM_LENGTH, alarm_len);
		write_reg(REG_BEEP_HALF, {junk[15:8], beep_half});
		run_cap = (debounce < 16'd8) ? 2 * debounce + 3 : 20;
	endtask

	task automatic send_tick(input tick_t t);
		if (src_idle != 0 && $urandom_range(0, 15) < src_idle * 3) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data  <= t;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Level and flow are held in runs long enough to pass the debounce most of
	// the time, with some random pin noise mixed in.
	task automatic run_ticks(input int count);
		tick_t t;
		for (int n = 0; n < count; n++) begin
			if (level_left == 0) begin
				level_dry  = ($urandom_range(0, 99) < dry_bias);
				level_left = $urandom_range(1, run_cap);
			end
			if (flow_left == 0) begin
				flow_off  = ($urandom_range(0, 99) < 30);
				flow_left = $urandom_range(1, run_cap);
			end
			level_left--;
			flow_left--;
			t.level_pin = level_dry;
			t.flow_pin  = flow_off;
			if ($urandom_range(0, 99) < 8) begin
				t.level_pin = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 99) < 8) begin
				t.flow_pin = 1'($urandom_range(0, 1));
			end
			send_tick(t);
		end
	endtask

	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		tick_ch.valid = 1'b0;
		tick_ch.data  = '0;
		src_idle      = 0;
		sink_stall    = 0;
		run_cap       = 4;
		dry_bias      = 50;
		level_left    = 0;
		flow_left     = 0;
		level_dry     = 1'b0;
		flow_off      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every pin combination under the reset timings, then all limits at zero.
		for (int i = 0; i < 20; i++) begin
			if (i == 4) begin
				settle();
				write_profile(16'd0, 24'd0, 24'd0, 4'd0, 24'd0, 24'd0, 16'd0);
				write_reg(REG_UNUSED, 24'hFFFFFF);
			end
			send_tick(DIRECTED_TICKS[39 - 2 * i -: 2]);
		end

		for (int p = 0; p < 7; p++) begin
			settle();
			src_idle   = (p == 6) ? 0 : $urandom_range(0, 3);
			sink_stall = (p == 6) ? 0 : $urandom_range(0, 3);
			dry_bias   = $urandom_range(25, 85);
			if (p == 0) begin
				write_profile(16'd1, 24'd1, 24'd1, 4'd0, 24'd1, 24'd1, 16'd1);
			end else begin
				write_profile(16'($urandom_range(0, 6)), 24'($urandom_range(0, 25)),
					24'($urandom_range(0, 40)), 4'($urandom_range(0, 15)),
					24'($urandom_range(0, 60)), 24'($urandom_range(0, 50)),
					16'($urandom_range(0, 6)));
			end
			run_ticks(170);
		end

		settle();
		write_profile(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'hF, 24'hFFFFFF, 24'hFFFFFF,
			16'hFFFF);
		run_ticks(100);

		settle();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
